// ===== sv/diff_drive_odometry_unit_assert.svh =====
// ----------------------------------------------------------------------------
// diff drive odometry assertion macros
// shared property wrappers for the odometry unit
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_ODOMETRY_UNIT_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define DDO_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define DDO_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DDO_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define DDO_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/ddo_pkg.sv =====
// ----------------------------------------------------------------------------
// ddo_pkg
// types, constants and tables of the differential drive odometry unit
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_IDX_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int FIFO_DEPTH   = 2;
  localparam int FIFO_PTR_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_LVL_W   = $clog2(FIFO_DEPTH + 1);

  localparam logic signed [33:0] INV_GAIN_Q30 = 34'sd652032874;
  localparam logic [47:0]        STEP_MAX     = 48'h7FFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    REG_TURN_GAIN     = 3'd0,
    REG_STEP_GAIN     = 3'd1,
    REG_INITIAL_ANGLE = 3'd2,
    REG_INITIAL_X     = 3'd3,
    REG_INITIAL_Y     = 3'd4,
    REG_LEFT_REVERSED = 3'd5
  } reg_index_e;

  typedef struct packed {
    logic signed [32:0] sum;
    logic signed [32:0] diff;
  } ddo_item_t;

  typedef struct packed {
    logic [31:0] turn_gain;
    logic [31:0] step_gain;
    logic [31:0] initial_angle;
  } ddo_cfg_t;

  typedef struct packed {
    logic        load_x;
    logic        load_y;
    logic [47:0] value;
  } ddo_load_t;

  function automatic logic [31:0] atan_lookup(logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/diff_drive_odometry_unit.sv =====
// ----------------------------------------------------------------------------
// diff_drive_odometry_unit
// wheel encoder odometry: heading and x/y position from encoder counts
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i/in_ready_o) carries absolute left and right
//   encoder counts; each transfer yields one result on the output channel
//   (out_valid_o/out_ready_i) with x, y and heading.
//   configuration channel (cfg_valid_i/cfg_ready_o) writes register
//   cfg_index_i with cfg_data_i; always ready, use only when idle.
//   the back end works on one item at a time: the iterative rotation
//   unit (CORDIC_STEPS, 16 rotations) and the four partial products of
//   the projections go through one back-end sequencer, which takes a new
//   item from the queue only after the last result is in the output register.
//   the front takes counts into a two-entry queue, so up to two items
//   are accepted while the back end works.
//   reset clears encoder history, accumulators and gains; left reversal
//   resets to 1. when the receiver stalls, the result holds in the output
//   register, the back end finishes the next item and waits, and the
//   input side stops once the queue is full.
// ----------------------------------------------------------------------------
`include "diff_drive_odometry_unit_assert.svh"

module diff_drive_odometry_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] left_count_i,
  input  logic [31:0] right_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [47:0] x_position_o,
  output logic [47:0] y_position_o,
  output logic [31:0] heading_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  ddo_pkg::ddo_cfg_t  cfg_q;
  logic               rev_q;
  ddo_pkg::ddo_load_t load;
  ddo_pkg::ddo_item_t push_item, pop_item;
  logic push, full, empty, pop, cfg_we;
  logic [ddo_pkg::FIFO_LVL_W-1:0] level;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  always_comb begin
    load.load_x = cfg_we && (cfg_index_i == ddo_pkg::REG_INITIAL_X);
    load.load_y = cfg_we && (cfg_index_i == ddo_pkg::REG_INITIAL_Y);
    load.value  = cfg_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
      rev_q <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index_i)
        ddo_pkg::REG_TURN_GAIN:     cfg_q.turn_gain     <= cfg_data_i[31:0];
        ddo_pkg::REG_STEP_GAIN:     cfg_q.step_gain     <= cfg_data_i[31:0];
        ddo_pkg::REG_INITIAL_ANGLE: cfg_q.initial_angle <= cfg_data_i[31:0];
        ddo_pkg::REG_LEFT_REVERSED: rev_q               <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  ddo_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .left_count_i   (left_count_i),
    .right_count_i  (right_count_i),
    .left_reversed_i(rev_q),
    .full_i         (full),
    .push_o         (push),
    .item_o         (push_item)
  );

  ddo_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_item),
    .full_o (full),
    .pop_i  (pop),
    .data_o (pop_item),
    .empty_o(empty),
    .level_o(level)
  );

  ddo_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(!empty),
    .item_i      (pop_item),
    .item_pop_o  (pop),
    .cfg_i       (cfg_q),
    .load_i      (load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .x_position_o(x_position_o),
    .y_position_o(y_position_o),
    .heading_o   (heading_o)
  );

  `DDO_ASSERT_IMP(a_level_bound, clk_i, rst_ni, 1'b1, level <= ddo_pkg::FIFO_LVL_W'(ddo_pkg::FIFO_DEPTH), "queue level above depth")
  `DDO_ASSERT_IMP(a_pop_nonempty, clk_i, rst_ni, pop, !empty, "pop from empty queue")
  `DDO_ASSERT_NXT(a_push_fills, clk_i, rst_ni, push && !pop, !empty, "queue empty after transfer")

endmodule

// ===== sv/ddo_fifo.sv =====
// ----------------------------------------------------------------------------
// ddo_fifo
// short queue of count sum and difference items between front and back
// ----------------------------------------------------------------------------
module ddo_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  ddo_pkg::ddo_item_t             data_i,
  output logic                           full_o,
  input  logic                           pop_i,
  output ddo_pkg::ddo_item_t             data_o,
  output logic                           empty_o,
  output logic [ddo_pkg::FIFO_LVL_W-1:0] level_o
);

  ddo_pkg::ddo_item_t mem_q [ddo_pkg::FIFO_DEPTH];
  logic [ddo_pkg::FIFO_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [ddo_pkg::FIFO_LVL_W-1:0] lvl_q, lvl_d;
  logic do_push, do_pop;

  assign full_o  = (lvl_q == ddo_pkg::FIFO_LVL_W'(ddo_pkg::FIFO_DEPTH));
  assign empty_o = (lvl_q == '0);
  assign level_o = lvl_q;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    lvl_d = lvl_q;
    if (do_push) begin
      wr_d = (wr_q == ddo_pkg::FIFO_PTR_W'(ddo_pkg::FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == ddo_pkg::FIFO_PTR_W'(ddo_pkg::FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      lvl_d = lvl_q + 1'b1;
    end else if (do_pop && !do_push) begin
      lvl_d = lvl_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      lvl_q <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== sv/ddo_front.sv =====
// ----------------------------------------------------------------------------
// ddo_front
// takes encoder counts, forms delta sum and count difference
// ----------------------------------------------------------------------------
module ddo_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        left_count_i,
  input  logic [31:0]        right_count_i,
  input  logic               left_reversed_i,
  input  logic               full_i,
  output logic               push_o,
  output ddo_pkg::ddo_item_t item_o
);

  logic [31:0] prev_l_q, prev_l_d, prev_r_q, prev_r_d;
  logic [31:0] l, dl, dr;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    // left count negation wraps at the most negative value
    l  = left_reversed_i ? (32'd0 - left_count_i) : left_count_i;
    dl = l - prev_l_q;
    dr = right_count_i - prev_r_q;
    item_o.sum  = $signed({dl[31], dl}) + $signed({dr[31], dr});
    item_o.diff = $signed({right_count_i[31], right_count_i}) - $signed({l[31], l});
    prev_l_d = push_o ? l : prev_l_q;
    prev_r_d = push_o ? right_count_i : prev_r_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_l_q <= '0;
      prev_r_q <= '0;
    end else begin
      prev_l_q <= prev_l_d;
      prev_r_q <= prev_r_d;
    end
  end

endmodule

// ===== sv/ddo_back.sv =====
// ----------------------------------------------------------------------------
// ddo_back
// heading, step length, iterative cordic and position update
// ----------------------------------------------------------------------------
module ddo_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  ddo_pkg::ddo_item_t item_i,
  output logic               item_pop_o,
  input  ddo_pkg::ddo_cfg_t  cfg_i,
  input  ddo_pkg::ddo_load_t load_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [47:0]        x_position_o,
  output logic [47:0]        y_position_o,
  output logic [31:0]        heading_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_HEAD, ST_STEP, ST_ROT, ST_PXH, ST_PXL, ST_PYH, ST_PYL, ST_DONE
  } state_e;

  state_e state_q;
  ddo_pkg::ddo_item_t item_q;
  logic [31:0]        head_q;
  logic [32:0]        mag_q;
  logic               neg_q, flip_q, pneg_q;
  logic [47:0]        dist_q;
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic [ddo_pkg::CORDIC_IDX_W-1:0] cnt_q;
  logic [61:0]        ph_q;
  logic [49:0]        pl_q;
  logic [47:0]        px_q;
  logic [47:0]        x_acc_q, y_acc_q;
  logic               ov_q;
  logic [47:0]        ox_q, oy_q;
  logic [31:0]        oh_q;

  logic signed [65:0] hprod;
  logic [64:0]        sprod;
  logic [31:0]        rot_a, head_plus_q;
  logic signed [33:0] xs, ys, at, cxf, cyf, csel;
  logic [33:0]        cabs;
  logic [31:0]        cmag;
  logic [61:0]        hi_prod;
  logic [49:0]        lo_prod;
  logic [50:0]        low_sum;
  logic [47:0]        comb, comb_s, y_new, x_new;
  logic               csel_neg;

  assign item_pop_o   = (state_q == ST_IDLE) && item_valid_i;
  assign out_valid_o  = ov_q;
  assign x_position_o = ox_q;
  assign y_position_o = oy_q;
  assign heading_o    = oh_q;

  always_comb begin
    hprod = $signed(item_q.diff) * $signed({1'b0, cfg_i.turn_gain});
    sprod = mag_q * cfg_i.step_gain;
    head_plus_q = head_q + 32'h4000_0000;
    rot_a = head_plus_q[31] ? (head_q + 32'h8000_0000) : head_q;
    xs = cx_q >>> cnt_q;
    ys = cy_q >>> cnt_q;
    at = $signed({2'b00, ddo_pkg::atan_lookup(5'(cnt_q))});
    cxf = flip_q ? -cx_q : cx_q;
    cyf = flip_q ? -cy_q : cy_q;
    csel = (state_q == ST_PXH || state_q == ST_PXL) ? cxf : cyf;
    csel_neg = csel[33];
    cabs = csel_neg ? 34'(-csel) : 34'(csel);
    cmag = cabs[31:0];
    hi_prod = dist_q[47:18] * cmag;
    lo_prod = dist_q[17:0] * cmag;
    // floor(dist * c / 2^30) from the two partial products
    low_sum = {21'd0, ph_q[11:0], 18'd0} + {1'b0, pl_q};
    comb = ph_q[59:12] + {27'd0, low_sum[50:30]};
    comb_s = pneg_q ? (48'd0 - comb) : comb;
    x_new = x_acc_q + px_q;
    y_new = y_acc_q + comb_s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
      x_acc_q <= '0;
      y_acc_q <= '0;
    end else begin
      if (ov_q && out_ready_i) begin
        ov_q <= 1'b0;
      end
      if (load_i.load_x) begin
        x_acc_q <= load_i.value;
      end
      if (load_i.load_y) begin
        y_acc_q <= load_i.value;
      end
      case (state_q)
        ST_IDLE: begin
          if (item_valid_i) begin
            state_q <= ST_HEAD;
          end
        end
        ST_HEAD: state_q <= ST_STEP;
        ST_STEP: state_q <= ST_ROT;
        ST_ROT: begin
          if (cnt_q == ddo_pkg::CORDIC_IDX_W'(ddo_pkg::CORDIC_STEPS - 1)) begin
            state_q <= ST_PXH;
          end
        end
        ST_PXH: state_q <= ST_PXL;
        ST_PXL: state_q <= ST_PYH;
        ST_PYH: state_q <= ST_PYL;
        ST_PYL: state_q <= ST_DONE;
        ST_DONE: begin
          if (!ov_q || out_ready_i) begin
            x_acc_q <= x_new;
            y_acc_q <= y_new;
            ov_q    <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        item_q <= item_i;
      end
      ST_HEAD: begin
        head_q <= cfg_i.initial_angle + hprod[47:16];
        neg_q  <= item_q.sum[32];
        mag_q  <= item_q.sum[32] ? 33'(-item_q.sum) : 33'(item_q.sum);
      end
      ST_STEP: begin
        dist_q <= (sprod[64:16] > {1'b0, ddo_pkg::STEP_MAX}) ? ddo_pkg::STEP_MAX
                                                               : sprod[63:16];
        // fold the angle into the half turn around zero
        flip_q <= head_plus_q[31];
        cz_q   <= $signed({{2{rot_a[31]}}, rot_a});
        cx_q   <= ddo_pkg::INV_GAIN_Q30;
        cy_q   <= '0;
        cnt_q  <= '0;
      end
      ST_ROT: begin
        if (!cz_q[33]) begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - at;
        end else begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + at;
        end
        cnt_q <= cnt_q + 1'b1;
      end
      ST_PXH: begin
        ph_q   <= hi_prod;
        pneg_q <= neg_q ^ csel_neg;
      end
      ST_PXL: begin
        pl_q <= lo_prod;
      end
      ST_PYH: begin
        px_q   <= comb_s;
        ph_q   <= hi_prod;
        pneg_q <= neg_q ^ csel_neg;
      end
      ST_PYL: begin
        pl_q <= lo_prod;
      end
      ST_DONE: begin
        if (!ov_q || out_ready_i) begin
          ox_q <= x_new;
          oy_q <= y_new;
          oh_q <= head_q;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== verif/diff_drive_odometry_unit_tb.sv =====
// ----------------------------------------------------------------------------
// diff_drive_odometry_unit_tb
// drives encoder count pairs and register writes into the odometry unit,
// predicts pose and heading per transfer and compares every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module diff_drive_odometry_unit_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 400;

  typedef struct {
    logic [47:0] x;
    logic [47:0] y;
    logic [31:0] heading;
  } pose_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] left_count_i;
  logic [31:0] right_count_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b1;
  logic [47:0] x_position_o;
  logic [47:0] y_position_o;
  logic [31:0] heading_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [47:0] cfg_data_i;

  diff_drive_odometry_unit dut (.*);

  // predictor state
  logic [31:0] pr_turn_gain, pr_step_gain, pr_init_angle;
  logic        pr_left_rev;
  logic [31:0] pr_prev_left, pr_prev_right;
  logic [47:0] pr_x_acc, pr_y_acc;

  longint atan_q32 [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0};

  pose_t expected_poses [$];
  int    mismatches = 0;
  int    idle_pct;
  int    stall_pct;
  int    hold_req = 0;
  int    hold_seen = 0;
  int    hold_cycles = 0;
  int    quiet_cycles = 0;
  int    enc_left, enc_right;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint project(longint d, longint c);
    logic        neg;
    logic [127:0] p;
    neg = (d < 0) ^ (c < 0);
    p = (128'(d < 0 ? -d : d) * 128'(c < 0 ? -c : c)) >> 30;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  task automatic predict_pose(input logic [31:0] lc, input logic [31:0] rc);
    logic [31:0] l, a, heading;
    longint sum, diff, prod, step_len, cx, cy, z, xs, ys;
    longint unsigned mag;
    logic   flip;
    int     n;
    pose_t  p;
    l = pr_left_rev ? -lc : lc;
    sum = longint'($signed(l - pr_prev_left)) + longint'($signed(rc - pr_prev_right));
    diff = longint'($signed(rc)) - longint'($signed(l));
    pr_prev_left = l;
    pr_prev_right = rc;
    prod = diff * longint'({32'b0, pr_turn_gain});
    heading = pr_init_angle + prod[47:16];
    mag = sum < 0 ? -sum : sum;
    mag = mag * pr_step_gain[31:16] + ((mag * pr_step_gain[15:0]) >> 16);
    if (mag > ddo_pkg::STEP_MAX) mag = ddo_pkg::STEP_MAX;
    step_len = sum < 0 ? -longint'(mag) : longint'(mag);
    // fold into the half turn around zero
    a = heading + 32'h4000_0000;
    flip = a[31];
    a = flip ? heading + 32'h8000_0000 : heading;
    z = longint'($signed(a));
    cx = ddo_pkg::INV_GAIN_Q30;
    cy = 0;
    n = ddo_pkg::CORDIC_STEPS > 32 ? 32 : ddo_pkg::CORDIC_STEPS;
    for (int i = 0; i < n; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (z >= 0) begin
        cx -= ys; cy += xs; z -= atan_q32[i];
      end else begin
        cx += ys; cy -= xs; z += atan_q32[i];
      end
    end
    if (flip) begin
      cx = -cx; cy = -cy;
    end
    prod = project(step_len, cx);
    pr_x_acc = pr_x_acc + prod[47:0];
    prod = project(step_len, cy);
    pr_y_acc = pr_y_acc + prod[47:0];
    p.x = pr_x_acc;
    p.y = pr_y_acc;
    p.heading = heading;
    expected_poses.push_back(p);
  endtask

  task automatic send_counts(input logic [31:0] lc, input logic [31:0] rc);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    left_count_i = lc;
    right_count_i = rc;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_pose(lc, rc);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_poses.size() != 0) @(posedge clk_i);
    // the last result may have left the output before the pipe is empty
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input ddo_pkg::reg_index_e idx, input logic [47:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      ddo_pkg::REG_TURN_GAIN:     pr_turn_gain = data[31:0];
      ddo_pkg::REG_STEP_GAIN:     pr_step_gain = data[31:0];
      ddo_pkg::REG_INITIAL_ANGLE: pr_init_angle = data[31:0];
      ddo_pkg::REG_INITIAL_X:     pr_x_acc = data;
      ddo_pkg::REG_INITIAL_Y:     pr_y_acc = data;
      ddo_pkg::REG_LEFT_REVERSED: pr_left_rev = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic write_all(input logic [31:0] tg, input logic [31:0] sg,
                           input logic [31:0] ang, input logic [47:0] x0,
                           input logic [47:0] y0, input logic lr);
    write_reg(ddo_pkg::REG_TURN_GAIN, {16'($urandom), tg});
    write_reg(ddo_pkg::REG_STEP_GAIN, {16'($urandom), sg});
    write_reg(ddo_pkg::REG_INITIAL_ANGLE, {16'($urandom), ang});
    write_reg(ddo_pkg::REG_INITIAL_X, x0);
    write_reg(ddo_pkg::REG_INITIAL_Y, y0);
    write_reg(ddo_pkg::REG_LEFT_REVERSED, {$urandom, 15'($urandom), lr});
  endtask

  task automatic test_directed();
    // registers beyond the list must be ignored
    write_reg(ddo_pkg::reg_index_e'(3'd6), {$urandom, 16'hffff});
    write_reg(ddo_pkg::reg_index_e'(3'd7), {$urandom, 16'hffff});
    write_all(32'h0100_0000, 32'h0001_0000, 32'h0, 48'h0, 48'h0, 1'b1);
    send_counts(32'd0, 32'd0);
    send_counts(32'd100, 32'd100);
    send_counts(32'h7fff_ffff, 32'h7fff_ffff);
    // encoder rollover seen as a small step
    send_counts(32'h8000_0000, 32'h8000_0000);
    send_counts(32'hffff_ffff, 32'h0);
    send_counts(32'h8000_0000, 32'h7fff_ffff);
    wait_idle();
    write_all(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              48'h7fff_ffff_ffff, 48'h8000_0000_0000, 1'b0);
    // saturation of the step and wrap of the accumulators
    send_counts(32'h7fff_ffff, 32'h7fff_ffff);
    send_counts(32'h8000_0000, 32'h8000_0000);
    send_counts(32'h7fff_ffff, 32'h8000_0000);
    send_counts(32'h0, 32'h0);
    send_counts(32'h8000_0000, 32'h7fff_ffff);
    wait_idle();
    write_all(32'h0, 32'h0, 32'h8000_0000, 48'h8000_0000_0000,
              48'h7fff_ffff_ffff, 1'b1);
    send_counts(32'h1234_5678, 32'h8765_4321);
    send_counts(32'h0, 32'h0);
    wait_idle();
    write_all(32'h4000_0000, 32'h0200_0000, 32'h4000_0000, 48'h0, 48'h0, 1'b0);
    for (int q = 0; q < 8; q++) send_counts(32'(-q * 4096), 32'(q * 4096));
    wait_idle();
  endtask

  task automatic test_random(input int ip, input int sp, input int items,
                             input logic press);
    idle_pct = ip;
    stall_pct = sp;
    write_all($urandom, $urandom, $urandom, {16'($urandom), $urandom},
              {16'($urandom), $urandom}, 1'($urandom));
    write_all($urandom_range(32'h0100_0000), $urandom_range(32'h0400_0000),
              $urandom, {16'($urandom), $urandom}, {16'($urandom), $urandom},
              1'($urandom));
    if (press) hold_req++;
    for (int k = 0; k < items; k++) begin
      if ($urandom_range(99) < 80) begin
        // well-formed wheel motion with small deltas
        enc_left += $urandom_range(400) - 200;
        enc_right += $urandom_range(400) - 200;
      end else begin
        enc_left = $urandom;
        enc_right = $urandom;
      end
      send_counts(enc_left, enc_right);
    end
    wait_idle();
  endtask

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cycles <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    pose_t e;
    if (out_valid_o && out_ready_i) begin
      if (expected_poses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result x=%h y=%h h=%h",
                                       x_position_o, y_position_o, heading_o);
      end else begin
        e = expected_poses.pop_front();
        if (e.x !== x_position_o || e.y !== y_position_o || e.heading !== heading_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pose mismatch exp x=%h y=%h h=%h got x=%h y=%h h=%h",
                     e.x, e.y, e.heading, x_position_o, y_position_o, heading_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    left_count_i = '0;
    right_count_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    idle_pct = 0;
    stall_pct = 0;
    enc_left = 0;
    enc_right = 0;
    pr_turn_gain = '0;
    pr_step_gain = '0;
    pr_init_angle = '0;
    pr_left_rev = 1'b1;
    pr_prev_left = '0;
    pr_prev_right = '0;
    pr_x_acc = '0;
    pr_y_acc = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(0, 0, 260, 1'b0);
    test_random(77, 0, 260, 1'b0);
    test_random(0, 77, 260, 1'b1);
    test_random(17, 17, 250, 1'b0);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ddo_pkg.sv
sv/ddo_fifo.sv
sv/ddo_front.sv
sv/ddo_back.sv
sv/diff_drive_odometry_unit.sv
verif/diff_drive_odometry_unit_tb.sv
